// ===== hdl/lcud_pkg.sv =====
// ----------------------------------------------------------------------------
// lcud_pkg
// Shared types, constants and helpers of the life cell update unit.
// ----------------------------------------------------------------------------
package lcud_pkg;

	localparam int CELL_W  = 8;
	localparam int COORD_W = 10;
	localparam int CFG_W   = 11;
	localparam int IDX_W   = 2;
	localparam int ODATA_W = 32;

	typedef logic [CELL_W-1:0]  cell_t;
	typedef logic [COORD_W-1:0] coord_t;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1
	} cfg_reg_t;

	localparam cell_t CELL_ALIVE  = 8'hFF;
	localparam cell_t CELL_DYING  = 8'h7F;
	localparam cell_t CELL_BORDER = 8'h00;

	// floor(v * 0.97) == (v * 63570) >> 16 exactly for every 8-bit v
	localparam int          FADE_SHIFT = 16;
	localparam logic [15:0] FADE_MULT  = 16'd63570;

	// Position and class of the cell a beat reports
	typedef struct packed {
		logic   have;
		logic   interior;
		logic   last;
		coord_t x;
		coord_t y;
	} pos_tag_t;

	function automatic cell_t fade(cell_t v);
		logic [23:0] p;
		p = 24'(v) * 24'(FADE_MULT);
		return p[FADE_SHIFT+CELL_W-1:FADE_SHIFT];
	endfunction

endpackage

// ===== hdl/lcud_line_mem.sv =====
// ----------------------------------------------------------------------------
// lcud_line_mem
// Two line stores packed in one synchronous RAM: {upper, middle} per column.
// ----------------------------------------------------------------------------
module lcud_line_mem import lcud_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output logic [2*CELL_W-1:0] rd_data,  // [7:0] middle, [15:8] upper
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  logic [2*CELL_W-1:0] wr_data
);

	logic [2*CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/lcud_rule.sv =====
// ----------------------------------------------------------------------------
// lcud_rule
// 3x3 window, B3/S23 rule with trail fade, and the output register.
// ----------------------------------------------------------------------------
module lcud_rule import lcud_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     col_valid,
	output logic     col_ready,
	input  cell_t    col_up,
	input  cell_t    col_mid,
	input  cell_t    col_bot,
	input  pos_tag_t col_tag,
	output logic     out_valid,
	input  logic     out_ready,
	output cell_t    out_value,
	output coord_t   out_x,
	output coord_t   out_y,
	output logic     out_last
);

	cell_t    win_q [3][3];  // [row][col], col 2 newest
	logic     valid_s2;
	pos_tag_t tag_s2;
	logic     s2_move;
	logic     out_free;
	logic [3:0] n_live;
	cell_t    center;
	cell_t    result;

	assign out_free  = !out_valid || out_ready;
	assign s2_move   = valid_s2 && (!tag_s2.have || out_free);
	assign col_ready = !valid_s2 || s2_move;

	always_ff @(posedge clk) begin
		if (col_valid && col_ready) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= col_up;
			win_q[1][2] <= col_mid;
			win_q[2][2] <= col_bot;
			tag_s2      <= col_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (col_ready) begin
			valid_s2 <= col_valid;
		end
	end

	always_comb begin
		n_live = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (!(i == 1 && j == 1)) begin
					n_live = n_live + 4'(win_q[i][j] == CELL_ALIVE);
				end
			end
		end
		center = win_q[1][1];
		if (!tag_s2.interior) begin
			result = CELL_BORDER;
		end else if (center == CELL_ALIVE) begin
			result = (n_live == 4'd2 || n_live == 4'd3) ? CELL_ALIVE : CELL_DYING;
		end else if (n_live == 4'd3) begin
			result = CELL_ALIVE;
		end else begin
			result = fade(center);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move && tag_s2.have) begin
			out_value <= result;
			out_x     <= tag_s2.x;
			out_y     <= tag_s2.y;
			out_last  <= tag_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s2_move && tag_s2.have) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule

// ===== hdl/life_cell_update_with_decay.sv =====
// ----------------------------------------------------------------------------
// life_cell_update_with_decay
// Streaming next-generation unit for a B3/S23 life grid with fading trails.
// ----------------------------------------------------------------------------
// Feed the current generation in raster order, one 8-bit cell per beat
// (255 = alive). The block takes one cell per clock while the output is not
// stalled and returns one result per cell once the pipeline is full; the rate
// is set by the single line store RAM, which is read at accept and written
// back when the cell leaves stage 1, so the two accesses of neighboring cells
// never touch the same column. A beat reports the next-generation value of the
// cell grid_width+1 positions behind the incoming one, with its column, row and
// a tlast on the last cell of the frame. After the cell that completes its
// window is accepted, a result passes the RAM read, the window and the output
// register, which holds it while m_tready is low. The first grid_width+1 cells
// after reset or a register write give no result; in later frames they report
// the previous frame's trailing border cells, which are 0. Border cells always
// give 0. Live cells become 255 with two or three live neighbors and 127
// otherwise; dead cells become 255 with exactly three, else fade to
// floor(v*0.97). Writing either dimension register saturates the value to
// 3..MAX and restarts the stream at row 0, column 0; write only while the
// pipeline is drained.
// ----------------------------------------------------------------------------
module life_cell_update_with_decay import lcud_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// slave side
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [CELL_W-1:0]  s_tdata,   // [7:0] cell_value
	// master side
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [ODATA_W-1:0] m_tdata,   // [7:0] new_value, [17:8] cell_x,
	                                      // [27:18] cell_y, [31:28] zero
	output logic               m_tlast,   // frame_last
	// configuration
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam logic [WW-1:0] WIDTH_RST  = WW'(640);
	localparam logic [HW-1:0] HEIGHT_RST = HW'(480);

	logic [WW-1:0] grid_width_q;
	logic [HW-1:0] grid_height_q;
	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic          primed_q;

	logic          accept;
	logic          restart;

	// stage 1: RAM read in flight
	logic          valid_s1;
	cell_t         cell_s1;
	logic [XW-1:0] addr_s1;
	pos_tag_t      tag_s1;
	logic          s1_move;

	logic [2*CELL_W-1:0] line_rd;
	logic          rule_ready;

	logic [XW-1:0] rx;
	logic [YW-1:0] ry;
	logic          have;
	pos_tag_t      tag_new;
	logic [31:0]   rx_wide;
	logic [31:0]   ry_wide;

	cell_t         out_value;
	coord_t        out_x;
	coord_t        out_y;

	function automatic logic [31:0] clamp_dim(logic [CFG_W-1:0] v, int hi);
		logic [31:0] r;
		if (v < CFG_W'(3)) begin
			r = 32'd3;
		end else if (32'(v) > 32'(hi)) begin
			r = 32'(hi);
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	assign restart = cfg_we && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

	// registers; any valid write restarts the stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= WIDTH_RST;
			grid_height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRID_WIDTH: begin
					grid_width_q <= WW'(clamp_dim(cfg_data, MAX_WIDTH));
				end
				REG_GRID_HEIGHT: begin
					grid_height_q <= HW'(clamp_dim(cfg_data, MAX_HEIGHT));
				end
				default: begin
				end
			endcase
		end
	end

	assign s1_move  = valid_s1 && rule_ready;
	assign s_tready = !valid_s1 || s1_move;
	assign accept   = s_tvalid && s_tready;

	// raster position of the next incoming cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			primed_q <= 1'b0;
		end else if (restart) begin
			col_q    <= '0;
			row_q    <= '0;
			primed_q <= 1'b0;
		end else if (accept) begin
			if (WW'(col_q) == grid_width_q - WW'(1)) begin
				col_q <= '0;
				if (HW'(row_q) == grid_height_q - HW'(1)) begin
					row_q    <= '0;
					primed_q <= 1'b1;
				end else begin
					row_q <= row_q + YW'(1);
				end
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// reported cell: one column back, one row up (two rows at column 0)
	always_comb begin
		have = 1'b1;
		if (col_q != '0) begin
			rx = col_q - XW'(1);
			if (row_q != '0) begin
				ry = row_q - YW'(1);
			end else begin
				ry   = YW'(grid_height_q - HW'(1));
				have = primed_q;
			end
		end else begin
			rx = XW'(grid_width_q - WW'(1));
			if (HW'(row_q) >= HW'(2)) begin
				ry = row_q - YW'(2);
			end else if (row_q != '0) begin
				ry   = YW'(grid_height_q - HW'(1));
				have = primed_q;
			end else begin
				ry   = YW'(grid_height_q - HW'(2));
				have = primed_q;
			end
		end
		rx_wide          = 32'(rx);
		ry_wide          = 32'(ry);
		tag_new.have     = have;
		tag_new.interior = (rx != '0) && (WW'(rx) <= grid_width_q - WW'(2)) &&
		                   (ry != '0) && (HW'(ry) <= grid_height_q - HW'(2));
		tag_new.last     = (WW'(rx) == grid_width_q - WW'(1)) &&
		                   (HW'(ry) == grid_height_q - HW'(1));
		tag_new.x        = rx_wide[COORD_W-1:0];
		tag_new.y        = ry_wide[COORD_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= s_tdata;
			addr_s1 <= col_q;
			tag_s1  <= tag_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// read at accept, write back {middle -> upper, new -> middle} on advance
	lcud_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (XW)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (line_rd),
		.wr_en   (s1_move),
		.wr_addr (addr_s1),
		.wr_data ({line_rd[CELL_W-1:0], cell_s1})
	);

	lcud_rule u_rule (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_valid (valid_s1),
		.col_ready (rule_ready),
		.col_up    (line_rd[2*CELL_W-1:CELL_W]),
		.col_mid   (line_rd[CELL_W-1:0]),
		.col_bot   (cell_s1),
		.col_tag   (tag_s1),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (out_value),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_last  (m_tlast)
	);

	assign m_tdata = {(ODATA_W - CELL_W - 2*COORD_W)'(0), out_y, out_x, out_value};

endmodule

// ===== hdl/lcud_checker.sv =====
// ----------------------------------------------------------------------------
// lcud_checker
// Port-level checks of the life cell update unit, bound to the top level.
// ----------------------------------------------------------------------------
module lcud_checker import lcud_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [ODATA_W-1:0] m_tdata,
	input logic               m_tlast
);

	// hold a stalled beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result beat changed");

	// last cell of a frame is a corner, hence border
	a_last_border: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[7:0] == CELL_BORDER)
		else $error("frame_last cell not zero");

	// first row and column are border
	a_edge_border: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[17:8] == '0 || m_tdata[27:18] == '0)
		|-> m_tdata[7:0] == CELL_BORDER)
		else $error("edge cell not zero");

	// fade never exceeds floor(254 * 0.97)
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] <= 8'd246 || m_tdata[7:0] == CELL_ALIVE))
		else $error("new_value out of reachable range");

endmodule

bind life_cell_update_with_decay lcud_checker u_lcud_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
